// ===== design/hcbp_pkg.sv =====
// Shared constants and types for the code-table bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int SYMBOL_COUNT  = 256;
  localparam int IDX_W         = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int MAX_CODE_BITS = 8;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  typedef struct packed {
    logic [3:0] len;
    logic [7:0] code;
  } entry_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] op;
    entry_t     entry;
  } stage_t;

endpackage

// ===== design/hcbp_if.sv =====
// Valid/ready channel interfaces for the input items and the packed bytes.
`timescale 1ns / 1ps

interface hcbp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] symbol;
  logic [3:0] code_length;
  logic [7:0] code_value;

  modport source (output valid, op, symbol, code_length, code_value, input ready);
  modport sink   (input valid, op, symbol, code_length, code_value, output ready);
endinterface

interface hcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== design/hcbp_code_table.sv =====
// Symbol code table: one write port, one registered read port, per-entry valid bits.
`timescale 1ns / 1ps

module hcbp_code_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic                rd_en,
  input  logic [7:0]          symbol,
  input  logic [3:0]          wr_len,
  input  logic [7:0]          wr_code,
  output hcbp_pkg::entry_t    rd_entry
);

  hcbp_pkg::entry_t                      mem [hcbp_pkg::SYMBOL_COUNT];
  logic [hcbp_pkg::SYMBOL_COUNT-1:0]     valid_r;
  hcbp_pkg::entry_t                      rd_data_r;
  logic                                  rd_hit_r;
  logic                                  in_range;
  logic [hcbp_pkg::IDX_W-1:0]            idx;
  hcbp_pkg::entry_t                      wr_entry;

  assign in_range = {1'b0, symbol} < 9'(hcbp_pkg::SYMBOL_COUNT);
  assign idx      = symbol[hcbp_pkg::IDX_W-1:0];

  always_comb begin
    wr_entry.code = wr_code;
    if (wr_len > 4'(hcbp_pkg::MAX_CODE_BITS)) begin
      wr_entry.len = 4'(hcbp_pkg::MAX_CODE_BITS);
    end else begin
      wr_entry.len = wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && in_range) begin
      mem[idx] <= wr_entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr_en && in_range) begin
        valid_r[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= in_range && valid_r[idx];
      end
    end
  end

  // Unwritten or out-of-range entries read as a zero-length code.
  assign rd_entry = rd_hit_r ? rd_data_r : '0;

`ifndef SYNTHESIS
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    rd_entry.len <= 4'(hcbp_pkg::MAX_CODE_BITS))
    else $error("table read length above maximum");
`endif

endmodule

// ===== design/hcbp_packer.sv =====
// Bit accumulator and result register: appends code bits, emits full and flushed bytes.
`timescale 1ns / 1ps

module hcbp_packer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hcbp_pkg::stage_t      stage,
  output logic                  stage_move,
  hcbp_out_if.source            out_ch
);

  logic [7:0]  acc_r,  acc_nxt;
  logic [2:0]  pend_r, pend_nxt;
  logic        out_valid_r;
  logic [7:0]  out_byte_r, byte_nxt;
  logic        out_last_r, last_nxt;
  logic        produce;
  logic        out_free;
  logic [3:0]  total;
  logic [15:0] combined;
  logic [15:0] new_bits;

  assign total    = {1'b0, pend_r} + stage.entry.len;
  assign new_bits = {8'h00, stage.entry.code} >> (4'd8 - stage.entry.len);
  assign combined = ({8'h00, acc_r} << stage.entry.len) | new_bits;

  always_comb begin
    produce  = 1'b0;
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    byte_nxt = 8'h00;
    last_nxt = 1'b0;
    case (stage.op)
      hcbp_pkg::OP_ENCODE: begin
        if (total[3]) begin
          produce  = 1'b1;
          byte_nxt = 8'(combined >> total[2:0]);
          pend_nxt = total[2:0];
          acc_nxt  = combined[7:0] & ~(8'hFF << total[2:0]);
        end else begin
          pend_nxt = total[2:0];
          acc_nxt  = combined[7:0];
        end
      end
      hcbp_pkg::OP_FLUSH: begin
        produce  = 1'b1;
        last_nxt = 1'b1;
        byte_nxt = 8'({8'h00, acc_r} << (4'd8 - {1'b0, pend_r}));
        pend_nxt = 3'd0;
        acc_nxt  = 8'h00;
      end
      default: begin
      end
    endcase
  end

  assign out_free   = !out_valid_r || out_ch.ready;
  assign stage_move = stage.vld && (!produce || out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'h00;
      pend_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (stage_move) begin
        acc_r  <= acc_nxt;
        pend_r <= pend_nxt;
      end
      if (stage_move && produce) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move && produce) begin
      out_byte_r <= byte_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

`ifndef SYNTHESIS
  a_acc_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_r & (8'hFF << pend_r)) == 8'h00)
    else $error("accumulator holds bits above the pending count");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    stage_move && stage.op == hcbp_pkg::OP_FLUSH |=> pend_r == 3'd0 && acc_r == 8'h00)
    else $error("flush left bits pending");

  a_zero_len_silent: assert property (@(posedge clk) disable iff (!rst_n)
    stage_move && stage.op == hcbp_pkg::OP_ENCODE && stage.entry.len == 4'd0
    |=> $stable(pend_r) && $stable(acc_r))
    else $error("zero-length code changed the accumulator");
`endif

endmodule

// ===== design/huffman_code_bit_packer_core.sv =====
// Top level of the code-table bit packer: input stage, table and packer.
// Items pass the input stage register (with its registered table read), then the result
// register. Throughput: one item per cycle unless an output stall holds the packer stage;
// the table's single registered read port sets the pipeline. Input stays open while the
// result register drains. Reset (rst_n low, synchronous) empties the pipeline and
// accumulator and marks all table entries unwritten, so they read as zero length at once.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core (
  input  logic         clk,
  input  logic         rst_n,
  hcbp_in_if.sink      in_ch,
  hcbp_out_if.source   out_ch
);

  logic              s1_vld_r;
  logic [1:0]        s1_op_r;
  logic              in_xfer;
  logic              stage_move;
  hcbp_pkg::entry_t  rd_entry;
  hcbp_pkg::stage_t  stage;

  assign in_ch.ready = !s1_vld_r || stage_move;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_xfer) begin
      s1_vld_r <= 1'b1;
    end else if (stage_move) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r <= in_ch.op;
    end
  end

  hcbp_code_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (in_xfer && in_ch.op == hcbp_pkg::OP_WRITE),
    .rd_en    (in_xfer),
    .symbol   (in_ch.symbol),
    .wr_len   (in_ch.code_length),
    .wr_code  (in_ch.code_value),
    .rd_entry (rd_entry)
  );

  always_comb begin
    stage.vld   = s1_vld_r;
    stage.op    = s1_op_r;
    stage.entry = rd_entry;
  end

  hcbp_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage      (stage),
    .stage_move (stage_move),
    .out_ch     (out_ch)
  );

endmodule

// ===== dv/hcbp_packing_checker.sv =====
// Checker for the bit packer: predicts packed bytes from accepted items and compares results.
`timescale 1ns / 1ps

module hcbp_packing_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_symbol,
  input  logic [3:0]  in_code_length,
  input  logic [7:0]  in_code_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        out_last,
  output int unsigned mismatches,
  output int unsigned expected_left,
  output int unsigned bytes_checked,
  output int unsigned streams_closed
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } packed_byte_t;

  packed_byte_t expected_bytes[$];
  logic [3:0]   len_tbl  [hcbp_pkg::SYMBOL_COUNT];
  logic [7:0]   code_tbl [hcbp_pkg::SYMBOL_COUNT];
  logic [7:0]   acc;
  logic [3:0]   nbits;
  int unsigned  n_fail;
  int unsigned  n_bytes;
  int unsigned  n_streams;

  always @(posedge clk) begin
    packed_byte_t want;
    logic [3:0]   len;
    if (!rst_n) begin
      for (int i = 0; i < hcbp_pkg::SYMBOL_COUNT; i++) begin
        len_tbl[i]  = '0;
        code_tbl[i] = '0;
      end
      acc = '0;
      nbits = '0;
      expected_bytes.delete();
      n_fail = 0;
      n_bytes = 0;
      n_streams = 0;
    end else begin
      if (in_valid && in_ready) begin
        case (in_op)
          hcbp_pkg::OP_WRITE: begin
            if (in_symbol < hcbp_pkg::SYMBOL_COUNT) begin
              len_tbl[in_symbol]  = (in_code_length > hcbp_pkg::MAX_CODE_BITS) ?
                                    4'(hcbp_pkg::MAX_CODE_BITS) : in_code_length;
              code_tbl[in_symbol] = in_code_value;
            end
          end
          hcbp_pkg::OP_ENCODE: begin
            len = (in_symbol < hcbp_pkg::SYMBOL_COUNT) ? len_tbl[in_symbol] : 4'd0;
            for (int i = 0; i < hcbp_pkg::MAX_CODE_BITS; i++) begin
              if (i < len) begin
                acc = {acc[6:0], code_tbl[in_symbol][7 - i]};
                nbits = nbits + 4'd1;
                if (nbits == 4'(hcbp_pkg::MAX_CODE_BITS)) begin
                  want.data = acc;
                  want.last = 1'b0;
                  expected_bytes.push_back(want);
                  acc = '0;
                  nbits = '0;
                end
              end
            end
          end
          hcbp_pkg::OP_FLUSH: begin
            // pending bits move to the top, zero padding below
            want.data = acc << (4'(hcbp_pkg::MAX_CODE_BITS) - nbits);
            want.last = 1'b1;
            expected_bytes.push_back(want);
            acc = '0;
            nbits = '0;
          end
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          n_fail++;
          $display("%0t: unexpected transfer, expected none, actual byte %02h last %0b",
                   $time, out_byte, out_last);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            n_fail++;
            $display("%0t: out_byte mismatch, expected %02h actual %02h",
                     $time, want.data, out_byte);
          end
          if (out_last !== want.last) begin
            n_fail++;
            $display("%0t: last mismatch, expected %0b actual %0b",
                     $time, want.last, out_last);
          end
          n_bytes++;
          if (want.last)
            n_streams++;
        end
      end
    end
    mismatches     <= n_fail;
    expected_left  <= expected_bytes.size();
    bytes_checked  <= n_bytes;
    streams_closed <= n_streams;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the bit packer testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0]  OP_SPARE    = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          ITEM_TARGET = 1250;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  hcbp_in_if  in_ch ();
  hcbp_out_if out_ch ();

  huffman_code_bit_packer_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  int unsigned mismatches;
  int unsigned expected_left;
  int unsigned bytes_checked;
  int unsigned streams_closed;

  hcbp_packing_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_op          (in_ch.op),
    .in_symbol      (in_ch.symbol),
    .in_code_length (in_ch.code_length),
    .in_code_value  (in_ch.code_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_byte       (out_ch.out_byte),
    .out_last       (out_ch.last),
    .mismatches     (mismatches),
    .expected_left  (expected_left),
    .bytes_checked  (bytes_checked),
    .streams_closed (streams_closed)
  );

  int unsigned cycle_count = 0;
  int unsigned items_sent  = 0;
  int unsigned op_count [4];
  int          send_calm   = 0;
  int          recv_calm   = 0;
  bit          hold_out    = 1'b0;
  bit          hold_done   = 1'b0;
  byte unsigned recent_syms[$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still owed", cycle_count, expected_left);
      $display("testbench: FAIL");
      $finish;
    end
  end

  // idle cycles before the next transfer; occasional runs with no idling
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [3:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2)
      return 4'd0;
    if (r < 5)
      return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  task automatic send(input logic [1:0] op, input logic [7:0] sym,
                      input logic [3:0] len, input logic [7:0] code);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.symbol      <= sym;
    in_ch.code_length <= len;
    in_ch.code_value  <= code;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    op_count[op]++;
  endtask

  // the checker's owed count is registered, so it lags behind the last transfer
  task automatic drain(input int tail);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic add_entry();
    logic [7:0] sym;
    logic [3:0] len;
    sym = 8'($urandom);
    len = pick_len();
    send(hcbp_pkg::OP_WRITE, sym, len, 8'($urandom));
    if (len != 0) begin
      recent_syms.push_back(sym);
      if (recent_syms.size() > 16)
        void'(recent_syms.pop_front());
    end
  endtask

  // table updates, a run of symbols from the live alphabet with some noise, then usually a flush
  task automatic run_stream();
    int n_enc;
    logic [7:0] sym;
    repeat ($urandom_range(0, 4)) add_entry();
    n_enc = $urandom_range(1, 40);
    repeat (n_enc) begin
      case ($urandom_range(0, 19))
        0: send(OP_SPARE, 8'($urandom), 4'($urandom), 8'($urandom));
        1: send(hcbp_pkg::OP_ENCODE, 8'($urandom), 4'($urandom), 8'($urandom));
        2: add_entry();
        default: begin
          sym = (recent_syms.size() != 0) ?
                recent_syms[$urandom_range(0, recent_syms.size() - 1)] : 8'($urandom);
          send(hcbp_pkg::OP_ENCODE, sym, 4'($urandom), 8'($urandom));
        end
      endcase
    end
    if ($urandom_range(0, 9) != 0)
      send(hcbp_pkg::OP_FLUSH, 8'($urandom), 4'($urandom), 8'($urandom));
  endtask

  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end
      gap = draw_wait(recv_calm);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.op          <= hcbp_pkg::OP_WRITE;
    in_ch.symbol      <= '0;
    in_ch.code_length <= '0;
    in_ch.code_value  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(hcbp_pkg::OP_ENCODE, 8'd0, 4'd0, 8'h00);   // entry never written: no bits
    send(hcbp_pkg::OP_FLUSH, 8'd0, 4'd0, 8'h00);    // empty flush
    send(hcbp_pkg::OP_WRITE, 8'd0, 4'd8, 8'hFF);
    send(hcbp_pkg::OP_WRITE, 8'd255, 4'd15, 8'h00); // length saturates
    send(hcbp_pkg::OP_WRITE, 8'd1, 4'd3, 8'hBF);    // bits below the length ignored
    send(hcbp_pkg::OP_WRITE, 8'd2, 4'd1, 8'h80);
    send(hcbp_pkg::OP_WRITE, 8'd3, 4'd0, 8'hAA);    // unused symbol
    send(hcbp_pkg::OP_WRITE, 8'd128, 4'd9, 8'h5A);
    send(OP_SPARE, 8'hFF, 4'hF, 8'hFF);
    send(hcbp_pkg::OP_ENCODE, 8'd0, 4'hF, 8'hFF);
    send(hcbp_pkg::OP_ENCODE, 8'd255, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd1, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd1, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd3, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd2, 4'd0, 8'h00);
    send(hcbp_pkg::OP_FLUSH, 8'd0, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd1, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd1, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd1, 4'd0, 8'h00);   // byte fills mid-code
    send(hcbp_pkg::OP_ENCODE, 8'd128, 4'd0, 8'h00);
    send(hcbp_pkg::OP_ENCODE, 8'd2, 4'd0, 8'h00);
    send(hcbp_pkg::OP_FLUSH, 8'hFF, 4'hF, 8'hFF);
    drain(4);

    while (items_sent < ITEM_TARGET) begin
      run_stream();
      if (!hold_done && items_sent > ITEM_TARGET / 2) begin
        // fill the block behind a long output stall
        send(hcbp_pkg::OP_WRITE, 8'd7, 4'd8, 8'($urandom));
        hold_out  = 1'b1;
        send_calm = 1000;
        repeat (48) send(hcbp_pkg::OP_ENCODE, 8'd7, 4'($urandom), 8'($urandom));
        send_calm = 0;
        send(hcbp_pkg::OP_FLUSH, 8'($urandom), 4'($urandom), 8'($urandom));
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 7) == 0)
        drain(4);
    end
    drain(8);

    $display("summary: %0d items: %0d table writes, %0d symbols, %0d flushes, %0d spare ops",
             items_sent, op_count[hcbp_pkg::OP_WRITE], op_count[hcbp_pkg::OP_ENCODE],
             op_count[hcbp_pkg::OP_FLUSH], op_count[OP_SPARE]);
    $display("summary: %0d bytes checked, %0d streams closed, %0d mismatches, %0d cycles",
             bytes_checked, streams_closed, mismatches, cycle_count);
    if (mismatches == 0 && expected_left == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule
